>>> design/csp_pkg.sv
package csp_pkg;

  localparam int STORE_WIDTH_DEF  = 256;
  localparam int STORE_HEIGHT_DEF = 256;
  localparam int CHANNELS_DEF     = 3;
  localparam int MAX_CH           = 3;

  localparam int SAMPLE_W = 8;   // one channel sample
  localparam int POS_W    = 12;  // coordinate fields
  localparam int CROPSZ_W = 9;   // crop width/height registers
  localparam int PATCH_W  = 13;  // patch width/height registers
  localparam int QFRAC_W  = 16;  // fraction bits of the Q9.16 step
  localparam int STEP_W   = CROPSZ_W + QFRAC_W;  // max step is 511 << 16
  localparam int PROD_W   = STEP_W + POS_W;
  localparam int FRAC_W   = 8;   // blend weight bits
  localparam int REG_W    = 13;  // config data width
  localparam int IDX_W    = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_CROP_LEFT    = 3'd0,
    REG_CROP_TOP     = 3'd1,
    REG_CROP_WIDTH   = 3'd2,
    REG_CROP_HEIGHT  = 3'd3,
    REG_PATCH_LEFT   = 3'd4,
    REG_PATCH_TOP    = 3'd5,
    REG_PATCH_WIDTH  = 3'd6,
    REG_PATCH_HEIGHT = 3'd7
  } reg_idx_t;

  // Blend weights for one pixel, shared by all lanes
  typedef struct packed {
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } weights_t;

endpackage

>>> design/csp_div.sv
// Restoring divider: quot = (num << 16) / den, one quotient bit per cycle.
// den of zero gives zero. quot holds until the next division completes.
module csp_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [csp_pkg::CROPSZ_W-1:0]       num,
  input  logic [csp_pkg::PATCH_W-1:0]        den,
  output logic [csp_pkg::STEP_W-1:0]         quot,
  output logic                               busy
);

  localparam int CNT_W = $clog2(csp_pkg::STEP_W + 1);

  logic [CNT_W-1:0]              cnt;
  logic [csp_pkg::STEP_W-1:0]    dvd;
  logic [csp_pkg::PATCH_W-1:0]   rem;
  logic [csp_pkg::PATCH_W-1:0]   den_r;
  logic [csp_pkg::PATCH_W:0]     rem_sh;
  logic [csp_pkg::PATCH_W:0]     rem_sub;
  logic                          qbit;

  assign rem_sh  = {rem, dvd[csp_pkg::STEP_W-1]};
  assign qbit    = rem_sh >= {1'b0, den_r};
  assign rem_sub = qbit ? rem_sh - {1'b0, den_r} : rem_sh;
  assign busy    = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      quot <= '0;
    end else if (start) begin
      cnt   <= CNT_W'(csp_pkg::STEP_W);
      dvd   <= {num, {csp_pkg::QFRAC_W{1'b0}}};
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      dvd <= {dvd[csp_pkg::STEP_W-2:0], qbit};
      rem <= rem_sub[csp_pkg::PATCH_W-1:0];
      if (cnt == CNT_W'(1)) begin
        quot <= (den_r == '0) ? '0 : {dvd[csp_pkg::STEP_W-2:0], qbit};
      end
    end
  end

endmodule

>>> design/csp_lane.sv
// One channel of the bilinear blend: horizontal pass, then vertical pass.
module csp_lane (
  input  logic                           clk,
  input  csp_pkg::weights_t              wt,
  input  logic [csp_pkg::SAMPLE_W-1:0]   a,
  input  logic [csp_pkg::SAMPLE_W-1:0]   b,
  input  logic [csp_pkg::SAMPLE_W-1:0]   c,
  input  logic [csp_pkg::SAMPLE_W-1:0]   d,
  output logic [csp_pkg::SAMPLE_W-1:0]   v
);

  localparam int W9  = csp_pkg::FRAC_W + 1;
  localparam int HW  = 2 * csp_pkg::SAMPLE_W;
  localparam int SW  = HW + csp_pkg::FRAC_W;

  logic [W9-1:0]                 wx0, wx1, wy0, wy1;
  logic [HW-1:0]                 top, bot;
  logic [csp_pkg::FRAC_W-1:0]    fy_d;
  logic [SW-1:0]                 sum;

  assign wx1 = W9'(wt.fx);
  assign wx0 = W9'(1 << csp_pkg::FRAC_W) - wx1;
  assign wy1 = W9'(fy_d);
  assign wy0 = W9'(1 << csp_pkg::FRAC_W) - wy1;
  assign sum = SW'(top) * SW'(wy0) + SW'(bot) * SW'(wy1);

  always_ff @(posedge clk) begin
    top  <= HW'(HW'(a) * HW'(wx0) + HW'(b) * HW'(wx1));
    bot  <= HW'(HW'(c) * HW'(wx0) + HW'(d) * HW'(wx1));
    fy_d <= wt.fy;
    v    <= sum[SW-1:HW];
  end

endmodule

>>> design/crop_scale_patch_bilinear_top.sv
// Crop, bilinear scale and paste.
// Command channel: a word is taken at a rising edge with start high and busy
// low. cmd 0 loads (pos_x, pos_y, in_ch*) into the source store; a load
// outside the store is dropped and no load gives a result. cmd 1 is a
// destination pixel: inside the patch it is scaled from the crop rectangle
// (four neighbours, truncating blend), outside the background passes.
// Results: out_ch*, in_patch are valid for the one cycle that strobe is
// high; the receiver cannot stall, so the pipe never holds back.
// A pixel word's result is registered through stages 1 to 5, then strobe.
// Throughput: one word per cycle, back to back, while busy is low. The store
// is split in four banks by column and row parity, so the 2x2 neighbourhood
// is one read per bank; a load writes one bank per cycle.
// Config: wr_en/wr_index/wr_data write a register. Each write recomputes
// both Q9.16 steps in bit-serial dividers: busy rises once div_go is
// registered and stays high until both finish; no word is taken meanwhile.
// Reset (rst, synchronous): registers take their reset values, steps are
// zero, the pipe empties. Store contents are not cleared; load a region
// before reading it.
module crop_scale_patch_bilinear_top #(
  parameter int STORE_WIDTH  = csp_pkg::STORE_WIDTH_DEF,
  parameter int STORE_HEIGHT = csp_pkg::STORE_HEIGHT_DEF,
  parameter int CHANNELS     = csp_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cmd,
  input  logic [csp_pkg::POS_W-1:0]          pos_x,
  input  logic [csp_pkg::POS_W-1:0]          pos_y,
  input  logic [csp_pkg::SAMPLE_W-1:0]       in_ch0,
  input  logic [csp_pkg::SAMPLE_W-1:0]       in_ch1,
  input  logic [csp_pkg::SAMPLE_W-1:0]       in_ch2,
  input  logic                               wr_en,
  input  logic [csp_pkg::IDX_W-1:0]          wr_index,
  input  logic [csp_pkg::REG_W-1:0]          wr_data,
  output logic                               strobe,
  output logic [csp_pkg::SAMPLE_W-1:0]       out_ch0,
  output logic [csp_pkg::SAMPLE_W-1:0]       out_ch1,
  output logic [csp_pkg::SAMPLE_W-1:0]       out_ch2,
  output logic                               in_patch
);

  localparam int PW    = csp_pkg::POS_W;
  localparam int SMP   = csp_pkg::SAMPLE_W;
  localparam int CW    = SMP * CHANNELS;
  localparam int HALFW = (STORE_WIDTH + 1) / 2;   // columns per bank
  localparam int HALFH = (STORE_HEIGHT + 1) / 2;  // rows per bank
  localparam int DEPTH = HALFW * HALFH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AFW   = 2 * PW;                  // wide address math
  localparam int SXW   = csp_pkg::PROD_W - csp_pkg::QFRAC_W + 1;
  localparam int BGW   = SMP * csp_pkg::MAX_CH;

  // ---------------- configuration registers ----------------
  logic [SMP-1:0]                   crop_left, crop_top;
  logic [csp_pkg::CROPSZ_W-1:0]     crop_width, crop_height;
  logic [PW-1:0]                    patch_left, patch_top;
  logic [csp_pkg::PATCH_W-1:0]      patch_width, patch_height;
  logic                             div_go;
  logic                             div_busy_x, div_busy_y;
  logic [csp_pkg::STEP_W-1:0]       step_x, step_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      crop_left    <= '0;
      crop_top     <= '0;
      crop_width   <= csp_pkg::CROPSZ_W'(1);
      crop_height  <= csp_pkg::CROPSZ_W'(1);
      patch_left   <= '0;
      patch_top    <= '0;
      patch_width  <= csp_pkg::PATCH_W'(1);
      patch_height <= csp_pkg::PATCH_W'(1);
      div_go       <= 1'b0;
    end else begin
      div_go <= wr_en;
      if (wr_en) begin
        unique case (csp_pkg::reg_idx_t'(wr_index))
          csp_pkg::REG_CROP_LEFT:    crop_left    <= wr_data[SMP-1:0];
          csp_pkg::REG_CROP_TOP:     crop_top     <= wr_data[SMP-1:0];
          csp_pkg::REG_CROP_WIDTH:   crop_width   <= wr_data[csp_pkg::CROPSZ_W-1:0];
          csp_pkg::REG_CROP_HEIGHT:  crop_height  <= wr_data[csp_pkg::CROPSZ_W-1:0];
          csp_pkg::REG_PATCH_LEFT:   patch_left   <= wr_data[PW-1:0];
          csp_pkg::REG_PATCH_TOP:    patch_top    <= wr_data[PW-1:0];
          csp_pkg::REG_PATCH_WIDTH:  patch_width  <= wr_data;
          csp_pkg::REG_PATCH_HEIGHT: patch_height <= wr_data;
          default: ;
        endcase
      end
    end
  end

  // steps restart in the cycle after a write, from the updated registers
  csp_div u_div_x (
    .clk(clk), .rst(rst), .start(div_go), .num(crop_width), .den(patch_width),
    .quot(step_x), .busy(div_busy_x)
  );
  csp_div u_div_y (
    .clk(clk), .rst(rst), .start(div_go), .num(crop_height), .den(patch_height),
    .quot(step_y), .busy(div_busy_y)
  );

  assign busy = div_go | div_busy_x | div_busy_y;

  // ---------------- stage 0: accept, patch test ----------------
  logic             accept;
  logic [PW-1:0]    off_x, off_y;
  logic             inside0, inrange0;

  assign accept   = start & ~busy;
  assign off_x    = pos_x - patch_left;
  assign off_y    = pos_y - patch_top;
  assign inside0  = (pos_x >= patch_left) && ({1'b0, off_x} < patch_width) &&
                    (pos_y >= patch_top) && ({1'b0, off_y} < patch_height);
  assign inrange0 = ({1'b0, pos_x} < (PW+1)'(STORE_WIDTH)) &&
                    ({1'b0, pos_y} < (PW+1)'(STORE_HEIGHT));

  // ---------------- stage 1 ----------------
  logic             v1, ld1, ins1;
  logic [PW-1:0]    offx1, offy1, lx1, ly1;
  logic [BGW-1:0]   bg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      ld1 <= 1'b0;
    end else begin
      v1  <= accept & cmd;
      ld1 <= accept & ~cmd & inrange0;
    end
    ins1  <= inside0;
    offx1 <= off_x;
    offy1 <= off_y;
    lx1   <= pos_x;
    ly1   <= pos_y;
    bg1   <= {in_ch2, in_ch1, in_ch0};
  end

  // load write: bank by parity, address inside the bank
  logic [1:0]       wbank;
  logic [AFW-1:0]   waddr_full;
  logic [AW-1:0]    waddr;

  assign wbank      = {ly1[0], lx1[0]};
  assign waddr_full = AFW'(ly1[PW-1:1]) * AFW'(HALFW) + AFW'(lx1[PW-1:1]);
  assign waddr      = waddr_full[AW-1:0];

  // ---------------- stage 2: scale multiply ----------------
  logic                          v2, ins2;
  logic [csp_pkg::PROD_W-1:0]    prodx2, prody2;
  logic [BGW-1:0]                bg2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    ins2   <= ins1;
    bg2    <= bg1;
    prodx2 <= csp_pkg::PROD_W'(step_x) * csp_pkg::PROD_W'(offx1);
    prody2 <= csp_pkg::PROD_W'(step_y) * csp_pkg::PROD_W'(offy1);
  end

  // neighbour positions with edge clamp
  logic [SXW-1:0]   sx, sy, sx1, sy1;
  logic [PW-1:0]    x0, x1, y0, y1;
  logic [PW-1:0]    col_e, col_o, row_e, row_o;

  assign sx  = SXW'(crop_left) + SXW'(prodx2[csp_pkg::PROD_W-1:csp_pkg::QFRAC_W]);
  assign sy  = SXW'(crop_top) + SXW'(prody2[csp_pkg::PROD_W-1:csp_pkg::QFRAC_W]);
  assign sx1 = sx + 1'b1;
  assign sy1 = sy + 1'b1;
  assign x0  = (sx  >= SXW'(STORE_WIDTH))  ? PW'(STORE_WIDTH - 1)  : sx[PW-1:0];
  assign x1  = (sx1 >= SXW'(STORE_WIDTH))  ? PW'(STORE_WIDTH - 1)  : sx1[PW-1:0];
  assign y0  = (sy  >= SXW'(STORE_HEIGHT)) ? PW'(STORE_HEIGHT - 1) : sy[PW-1:0];
  assign y1  = (sy1 >= SXW'(STORE_HEIGHT)) ? PW'(STORE_HEIGHT - 1) : sy1[PW-1:0];
  // x1 is x0+1 or x0 itself, so each parity bank needs one column
  assign col_e = x0[0] ? x1 : x0;
  assign col_o = x0[0] ? x0 : x1;
  assign row_e = y0[0] ? y1 : y0;
  assign row_o = y0[0] ? y0 : y1;

  // ---------------- stage 3: banked store read ----------------
  logic [CW-1:0]        rd [4];
  logic                 v3, ins3;
  logic                 x0p, x1p, y0p, y1p;
  csp_pkg::weights_t    wt3;
  logic [BGW-1:0]       bg3;

  for (genvar gb = 0; gb < 4; gb++) begin : g_bank
    logic [CW-1:0]   mem [DEPTH];
    logic [PW-1:0]   rcol, rrow;
    logic [AFW-1:0]  raddr_full;

    assign rcol       = gb[0] ? col_o : col_e;
    assign rrow       = gb[1] ? row_o : row_e;
    assign raddr_full = AFW'(rrow[PW-1:1]) * AFW'(HALFW) + AFW'(rcol[PW-1:1]);

    always_ff @(posedge clk) begin
      if (ld1 && wbank == 2'(gb)) begin
        mem[waddr] <= bg1[CW-1:0];
      end
      rd[gb] <= mem[raddr_full[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    ins3   <= ins2;
    bg3    <= bg2;
    x0p    <= x0[0];
    x1p    <= x1[0];
    y0p    <= y0[0];
    y1p    <= y1[0];
    wt3.fx <= prodx2[csp_pkg::QFRAC_W-1 -: csp_pkg::FRAC_W];
    wt3.fy <= prody2[csp_pkg::QFRAC_W-1 -: csp_pkg::FRAC_W];
  end

  logic [CW-1:0] na, nb, nc, nd;

  assign na = rd[{y0p, x0p}];
  assign nb = rd[{y0p, x1p}];
  assign nc = rd[{y1p, x0p}];
  assign nd = rd[{y1p, x1p}];

  // ---------------- stages 4-5: one blend lane per channel ----------------
  logic [SMP-1:0] lane_v [csp_pkg::MAX_CH];

  for (genvar gc = 0; gc < csp_pkg::MAX_CH; gc++) begin : g_lane
    if (gc < CHANNELS) begin : g_on
      csp_lane u_lane (
        .clk(clk), .wt(wt3),
        .a(na[gc*SMP +: SMP]), .b(nb[gc*SMP +: SMP]),
        .c(nc[gc*SMP +: SMP]), .d(nd[gc*SMP +: SMP]),
        .v(lane_v[gc])
      );
    end else begin : g_off
      assign lane_v[gc] = '0;
    end
  end

  logic             v4, v5, ins4, ins5;
  logic [BGW-1:0]   bg4, bg5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v4 <= v3;
      v5 <= v4;
    end
    ins4 <= ins3;
    ins5 <= ins4;
    bg4  <= bg3;
    bg5  <= bg4;
  end

  // ---------------- merge: scaled lanes or background ----------------
  logic [SMP-1:0] mrg [csp_pkg::MAX_CH];

  for (genvar gm = 0; gm < csp_pkg::MAX_CH; gm++) begin : g_merge
    if (gm < CHANNELS) begin : g_on
      assign mrg[gm] = ins5 ? lane_v[gm] : bg5[gm*SMP +: SMP];
    end else begin : g_off
      assign mrg[gm] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= v5;
    end
    out_ch0  <= mrg[0];
    out_ch1  <= mrg[1];
    out_ch2  <= mrg[2];
    in_patch <= ins5;
  end

`ifndef SYNTHESIS
  a_pixel_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd) |-> ##6 strobe)
    else $error("pixel word gave no result");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cmd) |-> ##6 !strobe)
    else $error("load word gave a result");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> busy)
    else $error("register write did not start step update");
`endif

endmodule
